### rtl/circle_cell_coverage_fraction_assert.svh
// ----------------------------------------------------------------------------
// circle_cell_coverage_fraction_assert.svh
// Assertion macros used by the port-level checker of the coverage block.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CELL_COVERAGE_FRACTION_ASSERT_SVH
`define CIRCLE_CELL_COVERAGE_FRACTION_ASSERT_SVH

// same-cycle implication
`define CCF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("coverage block assertion failed");

// next-cycle implication
`define CCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("coverage block assertion failed");

`endif

### rtl/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Types, codes and constants of the circle cell coverage block.
// ----------------------------------------------------------------------------
package ccf_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int MAX_SUB_DEF    = 8;
  localparam int MUL_CHUNK      = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int RAD_RESET      = 65536;
  localparam int SUB_RESET      = 4;
  localparam int FRAC_ONE       = 65536;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUB_X    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUB_Y    = 3'd4;

  localparam logic [1:0] REGION_OUTSIDE  = 2'd0;
  localparam logic [1:0] REGION_INSIDE   = 2'd1;
  localparam logic [1:0] REGION_BOUNDARY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EX, ST_EY, ST_SQD, ST_W, ST_H, ST_SQG, ST_CLASS,
    ST_LIM, ST_PY, ST_PX, ST_SCAN, ST_DIV, ST_DONE
  } ccf_state_e;

  typedef enum logic [2:0] {
    MSEL_EX, MSEL_EY, MSEL_W, MSEL_H, MSEL_KR, MSEL_PY, MSEL_PX
  } ccf_msel_e;

  typedef struct packed {
    logic      load;
    logic      mul_go;
    ccf_msel_e msel;
    logic      sqrt_go;
    logic      sqrt_g;
    logic      j_clr;
    logic      j_inc;
    logic      i_clr;
    logic      i_inc;
    logic      scan;
    logic      div_go;
    logic      out_load;
  } ccf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic boundary;
    logic j_last;
    logic i_last;
    logic out_busy;
  } ccf_sts_t;

endpackage

### rtl/circle_cell_coverage_fraction.sv
// ----------------------------------------------------------------------------
// circle_cell_coverage_fraction
// Classifies a rectangular cell against a circle and reports its coverage.
// ----------------------------------------------------------------------------
// One cell is worked on at a time; a finished result waits in the output
// register while the next cell is taken. A cell wholly inside or outside
// takes four squares on the chunked multiplier (COORD_BITS+KB+1 bits wide,
// 16 bits per cycle) and two bit-serial roots of COORD_BITS+3 steps each.
// A boundary cell adds 1+sub_x+sub_y further squares, a scan over every
// sub-cell sample and a restoring divide of 16 plus count-width steps.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module circle_cell_coverage_fraction import ccf_pkg::*; #(
  parameter int MAX_SUB    = MAX_SUB_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_BITS-1:0]   cell_left_i,
  input  logic [COORD_BITS-1:0]   cell_bottom_i,
  input  logic [COORD_BITS-2:0]   cell_width_i,
  input  logic [COORD_BITS-2:0]   cell_height_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              region_o,
  output logic [6:0]              inside_count_o,
  output logic [16:0]             fraction_o
);

  ccf_cmd_t cmd;
  ccf_sts_t sts;

  ccf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccf_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_SUB    (MAX_SUB)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cell_left_i    (cell_left_i),
    .cell_bottom_i  (cell_bottom_i),
    .cell_width_i   (cell_width_i),
    .cell_height_i  (cell_height_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .region_o       (region_o),
    .inside_count_o (inside_count_o),
    .fraction_o     (fraction_o)
  );

endmodule

### rtl/ccf_mul.sv
// ----------------------------------------------------------------------------
// ccf_mul
// Multi-cycle unsigned multiplier, one operand chunk per cycle.
// ----------------------------------------------------------------------------
module ccf_mul import ccf_pkg::*; #(
  parameter int W = 41
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] p_o
);

  localparam int CB   = MUL_CHUNK;
  localparam int NCH  = (W + CB - 1) / CB;
  localparam int BW   = NCH * CB;
  localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;

  logic [W-1:0]      a_q;
  logic [BW-1:0]     b_q;
  logic [BW+W-1:0]   acc_q, acc_d;
  logic [W+CB-1:0]   pp;
  logic [CNTW-1:0]   cnt_q;
  logic              busy_q, done_q;

  assign pp    = (W+CB)'(a_q) * (W+CB)'(b_q[BW-1 -: CB]);
  assign acc_d = (acc_q << CB) + (BW+W)'(pp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(NCH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      b_q   <= BW'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << CB;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[2*W-1:0];

endmodule

### rtl/ccf_sqrt.sv
// ----------------------------------------------------------------------------
// ccf_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ccf_sqrt import ccf_pkg::*; #(
  parameter int RB = 35
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [2*RB-1:0] n_i,
  output logic            done_o,
  output logic [RB-1:0]   root_o
);

  localparam int CW = $clog2(RB);

  logic [2*RB-1:0] n_q;
  logic [RB+1:0]   rem_q, rem_d;
  logic [RB-1:0]   root_q;
  logic [RB+2:0]   rsh, trial;
  logic            ge;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;

  assign rsh   = {rem_q[RB:0], n_q[2*RB-1 -: 2]};
  assign trial = (RB+3)'({root_q, 2'b01});
  assign ge    = rsh >= trial;
  assign rem_d = ge ? (RB+2)'(rsh - trial) : (RB+2)'(rsh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(RB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= n_q << 2;
      rem_q  <= rem_d;
      root_q <= {root_q[RB-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/ccf_dp.sv
// ----------------------------------------------------------------------------
// ccf_dp
// Datapath: configuration registers, cell operands, square and root units,
// sub-cell scan, fraction divider and output register.
// ----------------------------------------------------------------------------
module ccf_dp import ccf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SUB    = MAX_SUB_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_wdata_i,
  input  logic [COORD_BITS-1:0]   cell_left_i,
  input  logic [COORD_BITS-1:0]   cell_bottom_i,
  input  logic [COORD_BITS-2:0]   cell_width_i,
  input  logic [COORD_BITS-2:0]   cell_height_i,
  input  ccf_cmd_t                cmd_i,
  output ccf_sts_t                sts_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [1:0]              region_o,
  output logic [6:0]              inside_count_o,
  output logic [16:0]             fraction_o
);

  localparam int C    = COORD_BITS;
  localparam int KB   = $clog2(2 * MAX_SUB * MAX_SUB + 1);
  localparam int MW   = C + KB + 1;
  localparam int PS   = MW + 1;
  localparam int AW   = 2 * MW + 1;
  localparam int RB   = C + 3;
  localparam int SB   = $clog2(MAX_SUB + 1);
  localparam int JB   = (MAX_SUB > 1) ? $clog2(MAX_SUB) : 1;
  localparam int CNTB = $clog2(MAX_SUB * MAX_SUB + 1);
  localparam int QB   = CNTB + 16;
  localparam int QCB  = $clog2(QB);

  logic signed [C-1:0] cx_q, cy_q;
  logic [C-2:0]        rad_q;
  logic [3:0]          subx_q, suby_q;
  logic [SB-1:0]       sx_c, sy_c, sx_q, sy_q;
  logic [KB-1:0]       kv;

  logic signed [C:0]    dx, dy;
  logic signed [C+2:0]  ex_s, ey_s;
  logic [C+1:0]         exm_q, eym_q;
  logic [C-2:0]         w_q, h_q;
  logic signed [PS-1:0] kv_s, kdx_q, kdy_q, stepx_q, stepy_q, px_q, py_q;
  logic [MW-1:0]        kr_q, pxm, pym, mop;

  logic [2*MW-1:0] prod, lim_q, px2_q;
  logic [2*MW-1:0] py2_q [MAX_SUB];
  logic [AW-1:0]   acc_q, sum;
  logic            mul_done, sqrt_done;
  logic [RB-1:0]   root, d_q, g_q, r2, diff;
  logic            outside;

  logic [JB-1:0]   j_q, i_q;
  logic [CNTB-1:0] count_q, dv;

  logic [QB-1:0]   dnum_q;
  logic [CNTB-1:0] drem_q;
  logic [CNTB:0]   rsh;
  logic            dge;
  logic [QCB-1:0]  dcnt_q;
  logic            dbusy_q, ddone_q;
  logic [16:0]     frac_sat;

  logic            out_valid_q;
  logic [1:0]      region_q;
  logic [6:0]      count_out_q;
  logic [16:0]     frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      rad_q  <= (C-1)'(RAD_RESET);
      subx_q <= 4'(SUB_RESET);
      suby_q <= 4'(SUB_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: cx_q   <= cfg_wdata_i;
        REG_CENTER_Y: cy_q   <= cfg_wdata_i;
        REG_RADIUS:   rad_q  <= cfg_wdata_i[C-2:0];
        REG_SUB_X:    subx_q <= cfg_wdata_i[3:0];
        REG_SUB_Y:    suby_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign sx_c = (subx_q == 4'd0) ? SB'(1) : (subx_q > MAX_SUB) ? SB'(MAX_SUB) : SB'(subx_q);
  assign sy_c = (suby_q == 4'd0) ? SB'(1) : (suby_q > MAX_SUB) ? SB'(MAX_SUB) : SB'(suby_q);
  assign kv   = KB'(2 * sx_c * sy_c);
  assign kv_s = PS'(kv);

  assign dx   = (C+1)'($signed(cell_left_i)) - (C+1)'(cx_q);
  assign dy   = (C+1)'($signed(cell_bottom_i)) - (C+1)'(cy_q);
  assign ex_s = ((C+3)'(dx) <<< 1) + $signed((C+3)'(cell_width_i));
  assign ey_s = ((C+3)'(dy) <<< 1) + $signed((C+3)'(cell_height_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q     <= cell_width_i;
      h_q     <= cell_height_i;
      sx_q    <= sx_c;
      sy_q    <= sy_c;
      exm_q   <= ex_s[C+2] ? (C+2)'(-ex_s) : (C+2)'(ex_s);
      eym_q   <= ey_s[C+2] ? (C+2)'(-ey_s) : (C+2)'(ey_s);
      kdx_q   <= kv_s * PS'(dx);
      kdy_q   <= kv_s * PS'(dy);
      stepx_q <= PS'(sy_c) * PS'(cell_width_i);
      stepy_q <= PS'(sx_c) * PS'(cell_height_i);
      kr_q    <= MW'(kv) * MW'(rad_q);
    end
  end

  assign pxm = px_q[PS-1] ? MW'(-px_q) : MW'(px_q);
  assign pym = py_q[PS-1] ? MW'(-py_q) : MW'(py_q);

  always_comb begin
    case (cmd_i.msel)
      MSEL_EX: mop = MW'(exm_q);
      MSEL_EY: mop = MW'(eym_q);
      MSEL_W:  mop = MW'(w_q);
      MSEL_H:  mop = MW'(h_q);
      MSEL_KR: mop = kr_q;
      MSEL_PY: mop = pym;
      MSEL_PX: mop = pxm;
      default: mop = '0;
    endcase
  end

  ccf_mul #(.W(MW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (mop),
    .b_i    (mop),
    .done_o (mul_done),
    .p_o    (prod)
  );

  ccf_sqrt #(.RB(RB)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.sqrt_go),
    .n_i    (acc_q[2*RB-1:0]),
    .done_o (sqrt_done),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      case (cmd_i.msel)
        MSEL_EX, MSEL_W: acc_q <= AW'(prod);
        MSEL_EY, MSEL_H: acc_q <= acc_q + AW'(prod);
        MSEL_KR:         lim_q <= prod;
        MSEL_PY:         py2_q[j_q] <= prod;
        MSEL_PX:         px2_q <= prod;
        default: ;
      endcase
    end
    if (sqrt_done) begin
      if (cmd_i.sqrt_g) begin
        g_q <= root;
      end else begin
        d_q <= root;
      end
    end
  end

  assign r2      = RB'({rad_q, 1'b0});
  assign outside = d_q > r2;
  assign diff    = outside ? d_q - r2 : r2 - d_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.i_clr) begin
      i_q  <= '0;
      px_q <= kdx_q + stepx_q;
    end else if (cmd_i.i_inc) begin
      i_q  <= i_q + 1'b1;
      px_q <= px_q + (stepx_q <<< 1);
    end
    if (cmd_i.j_clr) begin
      j_q  <= '0;
      py_q <= kdy_q + stepy_q;
    end else if (cmd_i.j_inc) begin
      j_q  <= j_q + 1'b1;
      py_q <= py_q + (stepy_q <<< 1);
    end
  end

  assign sum = AW'(px2_q) + AW'(py2_q[j_q]);
  assign dv  = CNTB'(sx_q) * CNTB'(sy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= '0;
    end else if (cmd_i.scan && (sum <= AW'(lim_q))) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign rsh = {drem_q, dnum_q[QB-1]};
  assign dge = rsh >= (CNTB+1)'(dv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_go) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == QCB'(QB - 1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      dnum_q <= {count_q, 16'b0};
      drem_q <= '0;
    end else if (dbusy_q) begin
      dnum_q <= {dnum_q[QB-2:0], dge};
      drem_q <= dge ? CNTB'(rsh - (CNTB+1)'(dv)) : CNTB'(rsh);
    end
  end

  assign frac_sat = (dnum_q > QB'(FRAC_ONE)) ? 17'(FRAC_ONE) : dnum_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (diff < g_q) begin
        region_q    <= REGION_BOUNDARY;
        count_out_q <= 7'(count_q);
        frac_q      <= frac_sat;
      end else if (outside) begin
        region_q    <= REGION_OUTSIDE;
        count_out_q <= '0;
        frac_q      <= '0;
      end else begin
        region_q    <= REGION_INSIDE;
        count_out_q <= 7'((CNTB+7)'(dv));
        frac_q      <= 17'(FRAC_ONE);
      end
    end
  end

  assign sts_o.mul_done  = mul_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = ddone_q;
  assign sts_o.boundary  = diff < g_q;
  assign sts_o.j_last    = ((SB+1)'(j_q) + 1'b1) == (SB+1)'(sy_q);
  assign sts_o.i_last    = ((SB+1)'(i_q) + 1'b1) == (SB+1)'(sx_q);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign region_o       = region_q;
  assign inside_count_o = count_out_q;
  assign fraction_o     = frac_q;

endmodule

### rtl/ccf_ctrl.sv
// ----------------------------------------------------------------------------
// ccf_ctrl
// Sequencer: steps one cell through squares and roots and, for a boundary
// cell, sub-cell scan and division, then loads the output register.
// ----------------------------------------------------------------------------
module ccf_ctrl import ccf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ccf_sts_t sts_i,
  output ccf_cmd_t cmd_o
);

  ccf_state_e state_q, state_d;
  logic       armed_q, armed_d;
  logic       unit_done;

  assign unit_done = sts_i.mul_done || sts_i.sqrt_done || sts_i.div_done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EX;
      ST_EX:    if (sts_i.mul_done) state_d = ST_EY;
      ST_EY:    if (sts_i.mul_done) state_d = ST_SQD;
      ST_SQD:   if (sts_i.sqrt_done) state_d = ST_W;
      ST_W:     if (sts_i.mul_done) state_d = ST_H;
      ST_H:     if (sts_i.mul_done) state_d = ST_SQG;
      ST_SQG:   if (sts_i.sqrt_done) state_d = ST_CLASS;
      ST_CLASS: state_d = sts_i.boundary ? ST_LIM : ST_DONE;
      ST_LIM:   if (sts_i.mul_done) state_d = ST_PY;
      ST_PY:    if (sts_i.mul_done && sts_i.j_last) state_d = ST_PX;
      ST_PX:    if (sts_i.mul_done) state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.j_last) state_d = sts_i.i_last ? ST_DIV : ST_PX;
      end
      ST_DIV:   if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE:  if (!sts_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.msel = MSEL_EX;
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_EX: begin
        cmd_o.msel   = MSEL_EX;
        cmd_o.mul_go = !armed_q;
      end
      ST_EY: begin
        cmd_o.msel   = MSEL_EY;
        cmd_o.mul_go = !armed_q;
      end
      ST_SQD: cmd_o.sqrt_go = !armed_q;
      ST_W: begin
        cmd_o.msel   = MSEL_W;
        cmd_o.mul_go = !armed_q;
      end
      ST_H: begin
        cmd_o.msel   = MSEL_H;
        cmd_o.mul_go = !armed_q;
      end
      ST_SQG: begin
        cmd_o.sqrt_go = !armed_q;
        cmd_o.sqrt_g  = 1'b1;
      end
      ST_CLASS: ;
      ST_LIM: begin
        cmd_o.msel   = MSEL_KR;
        cmd_o.mul_go = !armed_q;
        cmd_o.j_clr  = sts_i.mul_done;
        cmd_o.i_clr  = sts_i.mul_done;
      end
      ST_PY: begin
        cmd_o.msel   = MSEL_PY;
        cmd_o.mul_go = !armed_q;
        cmd_o.j_inc  = sts_i.mul_done && !sts_i.j_last;
        cmd_o.j_clr  = sts_i.mul_done && sts_i.j_last;
      end
      ST_PX: begin
        cmd_o.msel   = MSEL_PX;
        cmd_o.mul_go = !armed_q;
      end
      ST_SCAN: begin
        cmd_o.scan  = 1'b1;
        cmd_o.j_inc = !sts_i.j_last;
        cmd_o.j_clr = sts_i.j_last;
        cmd_o.i_inc = sts_i.j_last && !sts_i.i_last;
      end
      ST_DIV:  cmd_o.div_go = !armed_q;
      ST_DONE: cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

  assign armed_d = ((state_d != state_q) || unit_done) ? 1'b0
                 : (armed_q || cmd_o.mul_go || cmd_o.sqrt_go || cmd_o.div_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      armed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### rtl/ccf_checker.sv
// ----------------------------------------------------------------------------
// ccf_checker
// Port-level checks of the coverage block, bound to the top level.
// ----------------------------------------------------------------------------
`include "circle_cell_coverage_fraction_assert.svh"

module ccf_checker import ccf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  region_o,
  input logic [6:0]  inside_count_o,
  input logic [16:0] fraction_o
);

  `CCF_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)
  `CCF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `CCF_ASSERT_SAME(a_outside_empty, out_valid_o && region_o == REGION_OUTSIDE, inside_count_o == 7'd0 && fraction_o == 17'd0)
  `CCF_ASSERT_SAME(a_inside_full, out_valid_o && region_o == REGION_INSIDE, fraction_o == 17'(FRAC_ONE))
  `CCF_ASSERT_SAME(a_frac_range, out_valid_o, fraction_o <= 17'(FRAC_ONE))

endmodule

bind circle_cell_coverage_fraction ccf_checker u_ccf_checker (.*);

### dv/ccf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccf_tb_checker
// Watches the cell and result channels of the coverage block, predicts the
// region, count and fraction of each accepted cell and compares in order.
// ----------------------------------------------------------------------------
module ccf_tb_checker import ccf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] cell_left_i,
  input  logic [31:0] cell_bottom_i,
  input  logic [30:0] cell_width_i,
  input  logic [30:0] cell_height_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  region_i,
  input  logic [6:0]  inside_count_i,
  input  logic [16:0] fraction_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        accept_o
);

  typedef struct packed {
    logic [1:0]  region;
    logic [6:0]  count;
    logic [16:0] frac;
  } coverage_t;

  coverage_t        coverage_q[$];
  logic signed [31:0] ctr_x, ctr_y;
  logic [30:0]      radius;
  logic [3:0]       subx, suby;

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic coverage_t predict_coverage(logic [31:0] l_raw, logic [31:0] b_raw,
                                                 logic [30:0] w_raw, logic [30:0] h_raw);
    logic signed [63:0] lft, bot, w, h, cx, cy, k;
    logic [63:0] ex, ey, d, g, r2, diff, sx, sy, px, py, kr, cnt, frac;
    logic [127:0] lim;
    coverage_t res;
    lft = $signed(l_raw); bot = $signed(b_raw);
    w = {33'd0, w_raw}; h = {33'd0, h_raw};
    cx = ctr_x; cy = ctr_y;
    sx = subx == 0 ? 1 : (subx > 8 ? 8 : subx);
    sy = suby == 0 ? 1 : (suby > 8 ? 8 : suby);
    ex = abs64(2 * lft + w - 2 * cx);
    ey = abs64(2 * bot + h - 2 * cy);
    d = isqrt128({64'd0, ex} * ex + {64'd0, ey} * ey);
    g = isqrt128({64'd0, w} * w + {64'd0, h} * h);
    r2 = 2 * {33'd0, radius};
    diff = d > r2 ? d - r2 : r2 - d;
    if (diff < g) begin
      k = 2 * sx * sy;
      kr = k * radius;
      lim = {64'd0, kr} * kr;
      cnt = 0;
      for (int i = 0; i < sx; i++) begin
        px = abs64(k * (lft - cx) + $signed((2 * i + 1) * sy) * w);
        for (int j = 0; j < sy; j++) begin
          py = abs64(k * (bot - cy) + $signed((2 * j + 1) * sx) * h);
          if ({64'd0, px} * px + {64'd0, py} * py <= lim) cnt++;
        end
      end
      frac = cnt * 65536 / (sx * sy);
      if (frac > FRAC_ONE) frac = FRAC_ONE;
      res = '{REGION_BOUNDARY, cnt[6:0], frac[16:0]};
    end else if (d > r2) begin
      res = '{REGION_OUTSIDE, 7'd0, 17'd0};
    end else begin
      cnt = sx * sy;
      res = '{REGION_INSIDE, cnt[6:0], 17'(FRAC_ONE)};
    end
    return res;
  endfunction

  assign pending_o = coverage_q.size();
  assign accept_o = (in_valid_i && !in_stall_i) || (out_valid_i && !out_stall_i);

  always @(posedge clk_i or negedge rst_ni) begin
    coverage_t want;
    if (!rst_ni) begin
      ctr_x <= '0; ctr_y <= '0; radius <= 31'(RAD_RESET);
      subx <= 4'(SUB_RESET); suby <= 4'(SUB_RESET);
      fail_count_o <= 0;
      coverage_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: ctr_x <= cfg_wdata_i;
          REG_CENTER_Y: ctr_y <= cfg_wdata_i;
          REG_RADIUS:   radius <= cfg_wdata_i[30:0];
          REG_SUB_X:    subx <= cfg_wdata_i[3:0];
          REG_SUB_Y:    suby <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        coverage_q.push_back(predict_coverage(cell_left_i, cell_bottom_i,
                                              cell_width_i, cell_height_i));
      if (out_valid_i && !out_stall_i) begin
        if (coverage_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %0d %0d %0d",
                                          region_i, inside_count_i, fraction_i);
        end else begin
          want = coverage_q.pop_front();
          if (want != {region_i, inside_count_i, fraction_i}) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("exp region %0d count %0d frac %0d, got %0d %0d %0d",
                       want.region, want.count, want.frac,
                       region_i, inside_count_i, fraction_i);
          end
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives cells and register settings into the coverage block with random
// idling and a long output hold-off; the checker judges every result.
// ----------------------------------------------------------------------------
module tb;
  import ccf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] cell_left_i = '0, cell_bottom_i = '0;
  logic [30:0] cell_width_i = 31'd1, cell_height_i = 31'd1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  region_o;
  logic [6:0]  inside_count_o;
  logic [16:0] fraction_o;
  int          fail_count, pending, idle_cycles;
  logic        accept;
  bit          calm, hold_off;

  always #10 clk_i = ~clk_i;

  circle_cell_coverage_fraction DUT (.*);

  ccf_tb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cell_left_i, .cell_bottom_i,
    .cell_width_i, .cell_height_i, .out_valid_i(out_valid_o), .out_stall_i,
    .region_i(region_o), .inside_count_i(inside_count_o), .fraction_i(fraction_o),
    .fail_count_o(fail_count), .pending_o(pending), .accept_o(accept)
  );

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= !calm && ($urandom_range(99) < 16);
  end

  always @(posedge clk_i) begin
    idle_cycles <= accept ? 0 : idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("circle_cell_coverage_fraction: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cell(logic [31:0] l, logic [31:0] b, logic [30:0] w, logic [30:0] h);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_left_i <= l; cell_bottom_i <= b; cell_width_i <= w; cell_height_i <= h;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_circle(logic [31:0] x, logic [31:0] y, logic [30:0] r,
                            logic [3:0] sx, logic [3:0] sy);
    write_reg(REG_CENTER_X, x); write_reg(REG_CENTER_Y, y);
    write_reg(REG_RADIUS, {1'b0, r});
    write_reg(REG_SUB_X, {28'd0, sx}); write_reg(REG_SUB_Y, {28'd0, sy});
    write_reg(3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic random_cell(int mode);
    logic [31:0] l, b;
    logic [30:0] w, h;
    if (mode < 6) begin
      w = 31'($urandom_range(1, 4 << 16)); h = 31'($urandom_range(1, 4 << 16));
      l = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      b = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    end else begin
      l = $urandom; b = $urandom;
      w = 31'($urandom); h = 31'($urandom);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
    end
    send_cell(l, b, w, h);
  endtask

  initial begin
    hold_off = 1'b0; calm = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_cell(32'h0000_0000, 32'h0000_0000, 31'h0000_8000, 31'h0000_8000);
    send_cell(32'hFFFF_C000, 32'hFFFF_C000, 31'h0000_8000, 31'h0000_8000);
    send_cell(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 31'd1);
    send_cell(32'h0001_0000, 32'h0000_0000, 31'h0001_0000, 31'h0001_0000);
    send_cell(32'h0000_0000, 32'h8000_0000, 31'd1, 31'h7FFF_FFFF);
    drain();
    set_circle(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 4'd8, 4'd8);
    send_cell(32'h8000_0000, 32'h7FFF_0000, 31'h0100_0000, 31'h0100_0000);
    send_cell(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    drain();
    set_circle(32'h0, 32'h0, 31'd0, 4'd0, 4'd15);
    send_cell(32'hFFFF_0000, 32'hFFFF_0000, 31'h0002_0000, 31'h0002_0000);
    send_cell(32'h0, 32'h0, 31'd1, 31'd1);
    drain();
    set_circle(32'h0, 32'h0, 31'h0002_0000, 4'd1, 4'd1);
    send_cell(32'hFFFF_0000, 32'h0001_0000, 31'h0002_0000, 31'h0002_0000);
    drain();
    for (int phase = 0; phase < 10; phase++) begin
      set_circle($signed($urandom_range(0, 4 << 16)) - (2 << 16),
                 $signed($urandom_range(0, 4 << 16)) - (2 << 16),
                 (phase == 9) ? 31'($urandom) : 31'($urandom_range(0, 4 << 16)),
                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      calm = (phase == 3);
      if (phase == 5) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (1500) @(posedge clk_i);
            hold_off = 1'b0;
          end
          for (int n = 0; n < 105; n++) random_cell($urandom_range(0, 7));
        join
      end else begin
        for (int n = 0; n < 105; n++) random_cell($urandom_range(0, 7));
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("circle_cell_coverage_fraction: match");
    end else begin
      $display("circle_cell_coverage_fraction: mismatch");
    end
    $finish;
  end

endmodule
